@@ rtl/c3br_pkg.sv @@
package c3br_pkg;

    localparam int MAX_WIDTH   = 64;
    localparam int MAX_HEIGHT  = 64;
    localparam int KERNEL_SIZE = 3;
    localparam int MIN_SIZE    = 3;

    localparam int PIX_W      = 8;
    localparam int WGT_W      = 8;
    localparam int ROW_WGT_W  = KERNEL_SIZE * WGT_W;
    localparam int PROD_W     = PIX_W + WGT_W + 1;
    localparam int ACC_W      = 21;
    localparam int SIZE_W     = 7;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int WIN_N      = KERNEL_SIZE * KERNEL_SIZE;
    localparam int LINE_W     = 2 * PIX_W;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = ROW_WGT_W;

    localparam logic [SIZE_W-1:0] WIDTH_RESET  = SIZE_W'(40);
    localparam logic [SIZE_W-1:0] HEIGHT_RESET = SIZE_W'(3);
    localparam logic [PIX_W-1:0]  PIX_MAX      = PIX_W'(255);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WEIGHT_ROW0 = 3'd0,
        CFG_WEIGHT_ROW1 = 3'd1,
        CFG_WEIGHT_ROW2 = 3'd2,
        CFG_BIAS        = 3'd3,
        CFG_WIDTH       = 3'd4,
        CFG_HEIGHT      = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic [KERNEL_SIZE-1:0][ROW_WGT_W-1:0] weight;
        logic [ACC_W-1:0]                      bias;
        logic [SIZE_W-1:0]                     width;
        logic [SIZE_W-1:0]                     height;
    } t_cfg;

    typedef logic [WIN_N-1:0][PIX_W-1:0] t_win;

    typedef struct packed {
        logic valid;
        logic last;
        t_win win;
    } t_mac_req;

endpackage

@@ rtl/c3br_in_if.sv @@
interface c3br_in_if;
    logic                        valid;
    logic                        ready;
    logic [c3br_pkg::PIX_W-1:0]  pixel_in;

    modport source (output valid, output pixel_in, input ready);
    modport sink (input valid, input pixel_in, output ready);
endinterface

@@ rtl/c3br_out_if.sv @@
interface c3br_out_if;
    logic                        valid;
    logic                        ready;
    logic [c3br_pkg::PIX_W-1:0]  pixel_out;
    logic                        frame_last;

    modport source (output valid, output pixel_out, output frame_last, input ready);
    modport sink (input valid, input pixel_out, input frame_last, output ready);
endinterface

@@ rtl/c3br_ram.sv @@
module c3br_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/c3br_regs.sv @@
module c3br_regs (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [c3br_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [c3br_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output c3br_pkg::t_cfg                  o_cfg
);

    c3br_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.weight <= '0;
            r_cfg.bias   <= '0;
            r_cfg.width  <= c3br_pkg::WIDTH_RESET;
            r_cfg.height <= c3br_pkg::HEIGHT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                c3br_pkg::CFG_WEIGHT_ROW0: begin
                    r_cfg.weight[0] <= i_cfg_data;
                end
                c3br_pkg::CFG_WEIGHT_ROW1: begin
                    r_cfg.weight[1] <= i_cfg_data;
                end
                c3br_pkg::CFG_WEIGHT_ROW2: begin
                    r_cfg.weight[2] <= i_cfg_data;
                end
                c3br_pkg::CFG_BIAS: begin
                    r_cfg.bias <= i_cfg_data[c3br_pkg::ACC_W-1:0];
                end
                c3br_pkg::CFG_WIDTH: begin
                    r_cfg.width <= i_cfg_data[c3br_pkg::SIZE_W-1:0];
                end
                c3br_pkg::CFG_HEIGHT: begin
                    r_cfg.height <= i_cfg_data[c3br_pkg::SIZE_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

@@ rtl/c3br_mac.sv @@
module c3br_mac (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  c3br_pkg::t_cfg     i_cfg,
    input  c3br_pkg::t_mac_req i_req,
    output logic               o_free,
    c3br_out_if.source         o_res
);

    logic signed [c3br_pkg::PROD_W-1:0] w_prod [c3br_pkg::WIN_N];
    logic signed [c3br_pkg::PROD_W-1:0] r_b_prod [c3br_pkg::WIN_N];
    logic        [c3br_pkg::ACC_W-1:0]  w_row_sum [c3br_pkg::KERNEL_SIZE];
    logic        [c3br_pkg::ACC_W-1:0]  r_c_sum [c3br_pkg::KERNEL_SIZE];
    logic        [c3br_pkg::ACC_W-1:0]  w_total;
    logic        [c3br_pkg::PIX_W-1:0]  w_clamped;
    logic                               r_b_valid;
    logic                               r_b_last;
    logic                               r_c_valid;
    logic                               r_c_last;
    logic                               r_o_valid;
    logic                               r_o_last;
    logic        [c3br_pkg::PIX_W-1:0]  r_o_pix;
    logic                               w_out_free;
    logic                               w_c_free;
    logic                               w_b_go;
    logic                               w_c_go;

    assign w_out_free = !r_o_valid || o_res.ready;
    assign w_c_free   = !r_c_valid || w_out_free;
    assign o_free     = !r_b_valid || w_c_free;
    assign w_b_go     = r_b_valid && w_c_free;
    assign w_c_go     = r_c_valid && w_out_free;

    always_comb begin
        for (int r = 0; r < c3br_pkg::KERNEL_SIZE; r++) begin
            for (int c = 0; c < c3br_pkg::KERNEL_SIZE; c++) begin
                w_prod[r*c3br_pkg::KERNEL_SIZE+c] =
                    c3br_pkg::PROD_W'($signed(i_cfg.weight[r][c*c3br_pkg::WGT_W +: c3br_pkg::WGT_W])
                    * $signed({1'b0, i_req.win[r*c3br_pkg::KERNEL_SIZE+c]}));
            end
        end
    end

    always_comb begin
        for (int r = 0; r < c3br_pkg::KERNEL_SIZE; r++) begin
            w_row_sum[r] = (r == 0) ? i_cfg.bias : '0;
            for (int c = 0; c < c3br_pkg::KERNEL_SIZE; c++) begin
                w_row_sum[r] = w_row_sum[r]
                    + {{(c3br_pkg::ACC_W-c3br_pkg::PROD_W)
                        {r_b_prod[r*c3br_pkg::KERNEL_SIZE+c][c3br_pkg::PROD_W-1]}},
                       r_b_prod[r*c3br_pkg::KERNEL_SIZE+c]};
            end
        end
    end

    assign w_total = r_c_sum[0] + r_c_sum[1] + r_c_sum[2];

    always_comb begin
        priority if (w_total[c3br_pkg::ACC_W-1]) begin
            w_clamped = '0;
        end else if (|w_total[c3br_pkg::ACC_W-2:c3br_pkg::PIX_W]) begin
            w_clamped = c3br_pkg::PIX_MAX;
        end else begin
            w_clamped = w_total[c3br_pkg::PIX_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (i_req.valid) begin
                r_b_valid <= 1'b1;
            end else if (w_c_free) begin
                r_b_valid <= 1'b0;
            end
            if (w_b_go) begin
                r_c_valid <= 1'b1;
            end else if (w_out_free) begin
                r_c_valid <= 1'b0;
            end
            if (w_c_go) begin
                r_o_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid) begin
            r_b_prod <= w_prod;
            r_b_last <= i_req.last;
        end
        if (w_b_go) begin
            r_c_sum  <= w_row_sum;
            r_c_last <= r_b_last;
        end
        if (w_c_go) begin
            r_o_pix  <= w_clamped;
            r_o_last <= r_c_last;
        end
    end

    assign o_res.valid      = r_o_valid;
    assign o_res.pixel_out  = r_o_pix;
    assign o_res.frame_last = r_o_last;

endmodule

@@ rtl/conv3x3_bias_relu_sat_top.sv @@
// Streaming 3x3 valid convolution with bias, ReLU and saturation to 8 bits.
// Pixels enter on i_pix one beat per pixel in raster order; i_pix.ready is
// high whenever the first pipeline stage is free or moving on.
// Results leave on o_res, one beat for each pixel at row two or more and
// column two or more, with frame_last set on the last result of a frame.
// The user must write the configuration port only while no pixel is in
// flight; the block does not enforce it. Both line stores share one
// 64-entry RAM with a registered read; the read for a pixel is issued when
// it is accepted, and the shifted line data is written back at the same
// column when the pixel leaves the first stage. The block takes one pixel
// per cycle while o_res is not stalled; the line RAM's single read and
// single write port each serve one pixel per cycle.
// Reset clears the counters, the window and the pipeline valid flags; the
// line RAM is not cleared and needs no clearing pass.
// When the receiver holds o_res.ready low, the result stays in the output
// register and the stages behind it keep filling until all are occupied,
// then i_pix.ready drops.
module conv3x3_bias_relu_sat_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    c3br_in_if.sink                         i_pix,
    c3br_out_if.source                      o_res,
    input  logic                            i_cfg_we,
    input  logic [c3br_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [c3br_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    c3br_pkg::t_cfg                    w_cfg;
    c3br_pkg::t_mac_req                w_req;
    c3br_pkg::t_win                    r_win;
    c3br_pkg::t_win                    w_win_next;
    logic [c3br_pkg::SIZE_W-1:0]       w_w;
    logic [c3br_pkg::SIZE_W-1:0]       w_h;
    logic [c3br_pkg::COL_W-1:0]        r_col;
    logic [c3br_pkg::ROW_W-1:0]        r_row;
    logic                              w_last_col;
    logic                              w_last_row;
    logic                              w_emit;
    logic                              w_acc;
    logic                              w_a_go;
    logic                              w_a_free;
    logic                              w_b_free;
    logic                              r_a_valid;
    logic                              r_a_emit;
    logic                              r_a_last;
    logic [c3br_pkg::PIX_W-1:0]        r_a_pix;
    logic [c3br_pkg::COL_W-1:0]        r_a_col;
    logic [c3br_pkg::LINE_W-1:0]       w_rdata;
    logic [c3br_pkg::PIX_W-1:0]        w_top;
    logic [c3br_pkg::PIX_W-1:0]        w_mid;

    c3br_regs u_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    always_comb begin
        priority if (w_cfg.width < c3br_pkg::SIZE_W'(c3br_pkg::MIN_SIZE)) begin
            w_w = c3br_pkg::SIZE_W'(c3br_pkg::MIN_SIZE);
        end else if (w_cfg.width > c3br_pkg::SIZE_W'(c3br_pkg::MAX_WIDTH)) begin
            w_w = c3br_pkg::SIZE_W'(c3br_pkg::MAX_WIDTH);
        end else begin
            w_w = w_cfg.width;
        end
        priority if (w_cfg.height < c3br_pkg::SIZE_W'(c3br_pkg::MIN_SIZE)) begin
            w_h = c3br_pkg::SIZE_W'(c3br_pkg::MIN_SIZE);
        end else if (w_cfg.height > c3br_pkg::SIZE_W'(c3br_pkg::MAX_HEIGHT)) begin
            w_h = c3br_pkg::SIZE_W'(c3br_pkg::MAX_HEIGHT);
        end else begin
            w_h = w_cfg.height;
        end
    end

    assign w_last_col = c3br_pkg::SIZE_W'(r_col) >= (w_w - c3br_pkg::SIZE_W'(1));
    assign w_last_row = c3br_pkg::SIZE_W'(r_row) >= (w_h - c3br_pkg::SIZE_W'(1));
    assign w_emit     = (r_row >= c3br_pkg::ROW_W'(2)) && (r_col >= c3br_pkg::COL_W'(2));

    assign w_a_go      = r_a_valid && (!r_a_emit || w_b_free);
    assign w_a_free    = !r_a_valid || w_a_go;
    assign i_pix.ready = w_a_free;
    assign w_acc       = i_pix.valid && w_a_free;

    c3br_ram #(
        .WIDTH (c3br_pkg::LINE_W),
        .DEPTH (c3br_pkg::MAX_WIDTH)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (w_a_go),
        .i_waddr (r_a_col),
        .i_wdata ({w_mid, r_a_pix}),
        .i_re    (w_acc),
        .i_raddr (r_col),
        .o_rdata (w_rdata)
    );

    assign w_top = w_rdata[c3br_pkg::LINE_W-1:c3br_pkg::PIX_W];
    assign w_mid = w_rdata[c3br_pkg::PIX_W-1:0];

    always_comb begin
        for (int r = 0; r < c3br_pkg::KERNEL_SIZE; r++) begin
            for (int c = 0; c < c3br_pkg::KERNEL_SIZE - 1; c++) begin
                w_win_next[r*c3br_pkg::KERNEL_SIZE+c] = r_win[r*c3br_pkg::KERNEL_SIZE+c+1];
            end
        end
        w_win_next[c3br_pkg::KERNEL_SIZE-1]   = w_top;
        w_win_next[2*c3br_pkg::KERNEL_SIZE-1] = w_mid;
        w_win_next[3*c3br_pkg::KERNEL_SIZE-1] = r_a_pix;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col     <= '0;
            r_row     <= '0;
            r_a_valid <= 1'b0;
            r_win     <= '0;
        end else begin
            if (w_acc) begin
                r_a_valid <= 1'b1;
                if (w_last_col) begin
                    r_col <= '0;
                    r_row <= w_last_row ? '0 : r_row + c3br_pkg::ROW_W'(1);
                end else begin
                    r_col <= r_col + c3br_pkg::COL_W'(1);
                end
            end else if (w_a_go) begin
                r_a_valid <= 1'b0;
            end
            if (w_a_go) begin
                r_win <= w_win_next;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_a_pix  <= i_pix.pixel_in;
            r_a_col  <= r_col;
            r_a_emit <= w_emit;
            r_a_last <= w_last_col && w_last_row;
        end
    end

    assign w_req.valid = w_a_go && r_a_emit;
    assign w_req.last  = r_a_last;
    assign w_req.win   = w_win_next;

    c3br_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg),
        .i_req   (w_req),
        .o_free  (w_b_free),
        .o_res   (o_res)
    );

endmodule

@@ tb/sv/conv3x3_bias_relu_sat_top_tb.sv @@
`timescale 1ns / 100ps

module conv3x3_bias_relu_sat_top_tb;
    import c3br_pkg::*;

    localparam int ITEMS_TARGET = 1700;
    localparam int STALL_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 12;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_A = CFG_IDX_W'(6);
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_B = CFG_IDX_W'(7);

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             last;
    } t_conv_res;

    class conv_window_model;
        t_cfg                            cfg;
        logic [MAX_WIDTH-1:0][PIX_W-1:0] line_above;
        logic [MAX_WIDTH-1:0][PIX_W-1:0] line_two_up;
        t_win                            win;
        logic [COL_W-1:0]                col_cnt;
        logic [ROW_W-1:0]                row_cnt;
        t_conv_res                       pending_res[$];
        int                              errors;

        function new();
            cfg.weight  = '0;
            cfg.bias    = '0;
            cfg.width   = WIDTH_RESET;
            cfg.height  = HEIGHT_RESET;
            line_above  = '0;
            line_two_up = '0;
            win         = '0;
            col_cnt     = '0;
            row_cnt     = '0;
            errors      = 0;
        endfunction

        function int eff_size(logic [SIZE_W-1:0] v, int hi);
            if (v < MIN_SIZE) return MIN_SIZE;
            if (v > hi) return hi;
            return int'(v);
        endfunction

        function int eff_width();
            return eff_size(cfg.width, MAX_WIDTH);
        endfunction

        function int eff_height();
            return eff_size(cfg.height, MAX_HEIGHT);
        endfunction

        function bit at_frame_start();
            return (col_cnt == '0) && (row_cnt == '0);
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_WEIGHT_ROW0: cfg.weight[0] = data[ROW_WGT_W-1:0];
                CFG_WEIGHT_ROW1: cfg.weight[1] = data[ROW_WGT_W-1:0];
                CFG_WEIGHT_ROW2: cfg.weight[2] = data[ROW_WGT_W-1:0];
                CFG_BIAS:        cfg.bias      = data[ACC_W-1:0];
                CFG_WIDTH:       cfg.width     = data[SIZE_W-1:0];
                CFG_HEIGHT:      cfg.height    = data[SIZE_W-1:0];
                default: ;
            endcase
        endfunction

        function logic [PIX_W-1:0] window_sum();
            logic [ACC_W-1:0]         acc;
            logic signed [PROD_W-1:0] prod;
            logic signed [WGT_W-1:0]  wgt;
            acc = cfg.bias;
            for (int r = 0; r < KERNEL_SIZE; r++) begin
                for (int c = 0; c < KERNEL_SIZE; c++) begin
                    wgt  = cfg.weight[r][WGT_W*c +: WGT_W];
                    prod = wgt * $signed({1'b0, win[r*KERNEL_SIZE+c]});
                    acc  = acc + {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod};
                end
            end
            if (acc[ACC_W-1]) return '0;
            if (acc > ACC_W'(PIX_MAX)) return PIX_MAX;
            return acc[PIX_W-1:0];
        endfunction

        function void note_pixel(logic [PIX_W-1:0] pix);
            int               w;
            int               h;
            logic             last_col;
            logic             last_row;
            logic [PIX_W-1:0] top;
            logic [PIX_W-1:0] mid;
            t_conv_res        res;
            w        = eff_width();
            h        = eff_height();
            last_col = int'(col_cnt) >= w - 1;
            last_row = int'(row_cnt) >= h - 1;
            top      = line_two_up[col_cnt];
            mid      = line_above[col_cnt];
            line_two_up[col_cnt] = mid;
            line_above[col_cnt]  = pix;
            for (int r = 0; r < KERNEL_SIZE; r++) begin
                win[r*KERNEL_SIZE]   = win[r*KERNEL_SIZE+1];
                win[r*KERNEL_SIZE+1] = win[r*KERNEL_SIZE+2];
            end
            win[KERNEL_SIZE-1]   = top;
            win[2*KERNEL_SIZE-1] = mid;
            win[3*KERNEL_SIZE-1] = pix;
            if ((row_cnt >= 2) && (col_cnt >= 2)) begin
                res.pixel = window_sum();
                res.last  = last_col && last_row;
                pending_res.push_back(res);
            end
            if (last_col) begin
                col_cnt = '0;
                row_cnt = last_row ? '0 : row_cnt + 1'b1;
            end else begin
                col_cnt = col_cnt + 1'b1;
            end
        endfunction

        task report_mismatch(string msg);
            errors++;
            $display("%0t ns mismatch: %s", $realtime, msg);
        endtask

        task check_result(logic [PIX_W-1:0] pix, logic last);
            t_conv_res want;
            if (pending_res.size() == 0) begin
                report_mismatch($sformatf("result beat %0d with no pixel pending", pix));
                return;
            end
            want = pending_res.pop_front();
            if (pix !== want.pixel) begin
                report_mismatch($sformatf("pixel_out %0d, expected %0d", pix, want.pixel));
            end
            if (last !== want.last) begin
                report_mismatch($sformatf("frame_last %0b, expected %0b", last, want.last));
            end
        endtask
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  sink_ready = 1'b0;
    int                    src_idle_pct = 0;
    int                    sink_idle_pct = 0;
    int                    sent_cnt = 0;
    int                    stall_cycles = 0;

    conv_window_model window_model;

    c3br_in_if  pix_if ();
    c3br_out_if res_if ();

    assign res_if.ready = sink_ready;

    conv3x3_bias_relu_sat_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_pix      (pix_if),
        .o_res      (res_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        sink_ready <= ($urandom_range(0, 99) >= sink_idle_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && res_if.valid && res_if.ready) begin
            window_model.check_result(res_if.pixel_out, res_if.frame_last);
        end
        if ((pix_if.valid && pix_if.ready) || (res_if.valid && res_if.ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        wait (stall_cycles >= STALL_LIMIT);
        $display("status: fail");
        $finish;
    end

    task automatic send_pixel(input logic [PIX_W-1:0] pix);
        if (sent_cnt < ITEMS_TARGET / 3) begin
            src_idle_pct  = 12;
            sink_idle_pct = 62;
        end else if (sent_cnt < 2 * ITEMS_TARGET / 3) begin
            src_idle_pct  = 62;
            sink_idle_pct = 12;
        end else begin
            src_idle_pct  = 0;
            sink_idle_pct = 0;
        end
        if ($urandom_range(0, 99) < src_idle_pct) begin
            pix_if.valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < src_idle_pct);
        end
        pix_if.valid    <= 1'b1;
        pix_if.pixel_in <= pix;
        do @(posedge i_clk); while (!pix_if.ready);
        window_model.note_pixel(pix);
        sent_cnt++;
    endtask

    // Results only come from the third row on, so pixels may still be in
    // flight once the last expected beat has arrived.
    task automatic wait_idle();
        pix_if.valid <= 1'b0;
        do @(posedge i_clk); while (window_model.pending_res.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge i_clk);
        window_model.write_reg(idx, data);
    endtask

    task automatic apply_cfg(input t_cfg c);
        logic [CFG_DATA_W-1:0] data;
        write_reg(CFG_WEIGHT_ROW0, c.weight[0]);
        write_reg(CFG_WEIGHT_ROW1, c.weight[1]);
        write_reg(CFG_WEIGHT_ROW2, c.weight[2]);
        data = CFG_DATA_W'($urandom);
        data[ACC_W-1:0] = c.bias;
        write_reg(CFG_BIAS, data);
        data = CFG_DATA_W'($urandom);
        data[SIZE_W-1:0] = c.width;
        write_reg(CFG_WIDTH, data);
        data = CFG_DATA_W'($urandom);
        data[SIZE_W-1:0] = c.height;
        write_reg(CFG_HEIGHT, data);
        write_reg($urandom_range(0, 1) ? CFG_UNUSED_A : CFG_UNUSED_B, CFG_DATA_W'($urandom));
        cfg_we <= 1'b0;
    endtask

    function automatic t_cfg pick_cfg();
        t_cfg             c;
        int               b;
        int               hot;
        logic [WGT_W-1:0] wb;
        case ($urandom_range(0, 3))
            0: begin
                for (int r = 0; r < KERNEL_SIZE; r++) c.weight[r] = ROW_WGT_W'($urandom);
                c.bias = ACC_W'($urandom);
            end
            1: begin
                for (int r = 0; r < KERNEL_SIZE; r++) begin
                    for (int k = 0; k < KERNEL_SIZE; k++) begin
                        c.weight[r][WGT_W*k +: WGT_W] = WGT_W'(int'($urandom_range(0, 2)) - 1);
                    end
                end
                c.bias = ACC_W'(int'($urandom_range(0, 600)) - 300);
            end
            2: begin
                c.weight = '0;
                hot = $urandom_range(0, WIN_N - 1);
                c.weight[hot / KERNEL_SIZE][WGT_W*(hot % KERNEL_SIZE) +: WGT_W] = WGT_W'(1);
                c.bias = ACC_W'(int'($urandom_range(0, 60)) - 30);
            end
            default: begin
                for (int r = 0; r < KERNEL_SIZE; r++) begin
                    for (int k = 0; k < KERNEL_SIZE; k++) begin
                        case ($urandom_range(0, 4))
                            0: wb = 8'h7F;
                            1: wb = 8'h80;
                            2: wb = 8'h00;
                            3: wb = 8'hFF;
                            default: wb = 8'h01;
                        endcase
                        c.weight[r][WGT_W*k +: WGT_W] = wb;
                    end
                end
                case ($urandom_range(0, 3))
                    0: b = (1 << (ACC_W - 1)) - 1;
                    1: b = -(1 << (ACC_W - 1));
                    2: b = 0;
                    default: b = int'($urandom);
                endcase
                c.bias = ACC_W'(b);
            end
        endcase
        case ($urandom_range(0, 9))
            0: begin
                c.width  = $urandom_range(0, 1) ? SIZE_W'(MAX_WIDTH) : SIZE_W'($urandom_range(65, 127));
                c.height = SIZE_W'($urandom_range(0, 4));
            end
            1: begin
                c.width  = SIZE_W'($urandom_range(0, 3));
                c.height = $urandom_range(0, 1) ? SIZE_W'(MAX_HEIGHT) : SIZE_W'($urandom_range(65, 127));
            end
            2: begin
                c.width  = SIZE_W'($urandom_range(0, 127));
                c.height = SIZE_W'($urandom_range(0, 3));
            end
            3: begin
                c.width  = SIZE_W'($urandom_range(0, 2));
                c.height = SIZE_W'($urandom_range(0, 2));
            end
            default: begin
                c.width  = SIZE_W'($urandom_range(3, 10));
                c.height = SIZE_W'($urandom_range(3, 6));
            end
        endcase
        // A row may only grow at a frame start, so no line entry that was
        // never written can reach a result.
        if (!window_model.at_frame_start() &&
            (window_model.eff_size(c.width, MAX_WIDTH) > window_model.eff_width())) begin
            c.width = window_model.cfg.width;
        end
        return c;
    endfunction

    initial begin
        t_cfg c;
        int   n;
        int   frames;
        window_model = new();
        i_rst_n         <= 1'b0;
        cfg_we          <= 1'b0;
        cfg_idx         <= '0;
        cfg_data        <= '0;
        pix_if.valid    <= 1'b0;
        pix_if.pixel_in <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Largest positive weights on top of the largest bias wrap negative.
        c.weight = {KERNEL_SIZE{24'h7F7F7F}};
        c.bias   = 21'h0FFFFF;
        c.width  = SIZE_W'(3);
        c.height = SIZE_W'(3);
        apply_cfg(c);
        repeat (WIN_N) send_pixel(PIX_MAX);

        // Most negative weights under the smallest bias wrap positive, and
        // sizes below the minimum are taken as the minimum.
        wait_idle();
        c.weight = {KERNEL_SIZE{24'h808080}};
        c.bias   = 21'h100000;
        c.width  = '0;
        c.height = SIZE_W'(1);
        apply_cfg(c);
        for (int i = 0; i < WIN_N; i++) send_pixel(i[0] ? PIX_MAX : '0);

        // The row shrinks below the current column in the middle of a frame.
        wait_idle();
        c.weight[0] = 24'h01807F;
        c.weight[1] = 24'hFF0002;
        c.weight[2] = 24'h7F80FE;
        c.bias      = '0;
        c.width     = SIZE_W'(6);
        c.height    = SIZE_W'(3);
        apply_cfg(c);
        repeat (5) send_pixel(PIX_W'($urandom_range(0, 255)));
        wait_idle();
        c.width = SIZE_W'(3);
        apply_cfg(c);
        send_pixel(PIX_W'($urandom_range(0, 255)));

        while (sent_cnt < ITEMS_TARGET) begin
            wait_idle();
            apply_cfg(pick_cfg());
            n = window_model.eff_width() * window_model.eff_height();
            if ($urandom_range(0, 4) == 0) begin
                repeat ($urandom_range(1, n - 1)) send_pixel(PIX_W'($urandom_range(0, 255)));
            end else begin
                frames = (n > 100) ? 1 : $urandom_range(1, 3);
                while (frames > 0) begin
                    send_pixel(PIX_W'($urandom_range(0, 255)));
                    if (window_model.at_frame_start()) frames--;
                end
            end
        end

        wait_idle();
        if (window_model.errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

@@ conv3x3_bias_relu_sat_top.f @@
rtl/c3br_pkg.sv
rtl/c3br_in_if.sv
rtl/c3br_out_if.sv
rtl/c3br_ram.sv
rtl/c3br_regs.sv
rtl/c3br_mac.sv
rtl/conv3x3_bias_relu_sat_top.sv
tb/sv/conv3x3_bias_relu_sat_top_tb.sv
